// ===== rtl/matrix4x4_multiply_assert.svh =====
// assertion macros for the matrix multiplier
// the module that uses them has clk and rst_n in scope
`ifndef MATRIX4X4_MULTIPLY_ASSERT_SVH
`define MATRIX4X4_MULTIPLY_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MM4_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// next-cycle implication
`define MM4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define MM4_ASSERT_SAME(label, ante, cons)
`define MM4_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/mm4_pkg.sv =====
`default_nettype none

package mm4_pkg;

    localparam int DIM     = 4;
    localparam int CELLS   = DIM * DIM;
    localparam int IDX_W   = 2;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int ENTRY_W = 32;
    localparam int PROD_W  = 2 * ENTRY_W;
    // four products summed need two guard bits
    localparam int ACC_W   = PROD_W + 2;

    localparam logic [IDX_W-1:0] IDX_FIRST = '0;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DIM - 1);

    // request codes
    localparam logic [1:0] REQ_WR_LEFT  = 2'd0;
    localparam logic [1:0] REQ_WR_RIGHT = 2'd1;
    localparam logic [1:0] REQ_RD_LEFT  = 2'd2;
    localparam logic [1:0] REQ_MUL      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT,
        ST_WBACK
    } state_t;

    typedef struct packed {
        logic              wr_left_in;
        logic              wr_right_in;
        logic              mul_en;
        logic              acc_clr;
        logic              emit_read;
        logic              emit_prod;
        logic              last;
        logic              wb_en;
        logic [ADDR_W-1:0] l_addr;
        logic [ADDR_W-1:0] r_addr;
        logic [IDX_W-1:0]  i;
        logic [IDX_W-1:0]  j;
        logic [IDX_W-1:0]  k;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/mm4_dp.sv =====
`default_nettype none

module mm4_dp #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  mm4_pkg::cmd_t                       cmd,
    output mm4_pkg::status_t                    status,
    input  wire  [mm4_pkg::IDX_W-1:0]           row,
    input  wire  [mm4_pkg::IDX_W-1:0]           col,
    input  wire  signed [mm4_pkg::ENTRY_W-1:0]  value,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [mm4_pkg::IDX_W-1:0]           out_row,
    output logic [mm4_pkg::IDX_W-1:0]           out_col,
    output logic signed [mm4_pkg::ENTRY_W-1:0]  entry,
    output logic                                saturated,
    output logic                                last
);
    import mm4_pkg::*;

    logic signed [ENTRY_W-1:0] left_reg  [CELLS];
    logic signed [ENTRY_W-1:0] right_reg [CELLS];
    logic signed [ENTRY_W-1:0] rowbuf_reg [DIM];

    logic signed [ENTRY_W-1:0] left_rd;
    logic signed [ENTRY_W-1:0] right_rd;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      prod_vld_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_shift;
    logic [ACC_W-ENTRY_W:0]    acc_hi;
    logic signed [ENTRY_W-1:0] sat_val;
    logic                      sat_flag;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [IDX_W-1:0]          out_row_reg;
    logic [IDX_W-1:0]          out_col_reg;
    logic signed [ENTRY_W-1:0] entry_reg;
    logic                      saturated_reg;
    logic                      last_reg;
    logic                      out_load;

    assign left_rd  = left_reg[cmd.l_addr];
    assign right_rd = right_reg[cmd.r_addr];

    // entry stores, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < CELLS; n++)
            begin
                left_reg[n]  <= '0;
                right_reg[n] <= '0;
            end
        end
        else
        begin
            if (cmd.wr_left_in)
            begin
                left_reg[{row, col}] <= value;
            end
            else if (cmd.wb_en)
            begin
                left_reg[{cmd.i, cmd.k}] <= rowbuf_reg[cmd.k];
            end
            if (cmd.wr_right_in)
            begin
                right_reg[{row, col}] <= value;
            end
        end
    end

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= left_rd * right_rd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    // accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // floor shift then clip to the entry range
    assign acc_shift = acc_reg >>> FRAC_BITS;
    assign acc_hi    = acc_shift[ACC_W-1:ENTRY_W-1];

    always_comb
    begin
        sat_flag = !((&acc_hi) || !(|acc_hi));
        if (!sat_flag)
        begin
            sat_val = acc_shift[ENTRY_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            sat_val = {1'b1, {(ENTRY_W - 1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(ENTRY_W - 1){1'b1}}};
        end
    end

    // product row held until write-back
    always_ff @(posedge clk)
    begin
        if (cmd.emit_prod)
        begin
            rowbuf_reg[cmd.j] <= sat_val;
        end
    end

    // output register
    assign out_load        = cmd.emit_read || cmd.emit_prod;
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_read)
        begin
            out_row_reg   <= cmd.l_addr[ADDR_W-1:IDX_W];
            out_col_reg   <= cmd.l_addr[IDX_W-1:0];
            entry_reg     <= left_rd;
            saturated_reg <= 1'b0;
            last_reg      <= cmd.last;
        end
        else if (cmd.emit_prod)
        begin
            out_row_reg   <= cmd.i;
            out_col_reg   <= cmd.j;
            entry_reg     <= sat_val;
            saturated_reg <= sat_flag;
            last_reg      <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign entry     = entry_reg;
    assign saturated = saturated_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== rtl/mm4_ctrl.sv =====
`default_nettype none

`include "matrix4x4_multiply_assert.svh"

module mm4_ctrl (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  [1:0]                 req_type,
    input  wire  [mm4_pkg::IDX_W-1:0]  row,
    input  wire  [mm4_pkg::IDX_W-1:0]  col,
    output mm4_pkg::cmd_t              cmd,
    input  mm4_pkg::status_t           status
);
    import mm4_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   i_next;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   j_next;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   k_next;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [ADDR_W-1:0]  rd_addr_next;
    logic               in_fire;

    assign in_fire = in_valid && (state_reg == ST_IDLE);

    // next state and counters
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        rd_addr_next = rd_addr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == REQ_RD_LEFT)
                    begin
                        rd_addr_next = {row, col};
                        state_next   = ST_READ;
                    end
                    else if (req_type == REQ_MUL)
                    begin
                        i_next     = IDX_FIRST;
                        j_next     = IDX_FIRST;
                        k_next     = IDX_FIRST;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_READ:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == IDX_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (j_reg == IDX_LAST)
                    begin
                        k_next     = IDX_FIRST;
                        state_next = ST_WBACK;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end
            ST_WBACK:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == IDX_LAST)
                begin
                    j_next = IDX_FIRST;
                    if (i_reg == IDX_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            rd_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            rd_addr_reg <= rd_addr_next;
        end
    end

    // command outputs
    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.i           = i_reg;
        cmd.j           = j_reg;
        cmd.k           = k_reg;
        cmd.l_addr      = {i_reg, k_reg};
        cmd.r_addr      = {k_reg, j_reg};
        cmd.last        = (i_reg == IDX_LAST) && (j_reg == IDX_LAST);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.wr_left_in  = in_valid && (req_type == REQ_WR_LEFT);
                cmd.wr_right_in = in_valid && (req_type == REQ_WR_RIGHT);
            end
            ST_READ:
            begin
                cmd.l_addr    = rd_addr_reg;
                cmd.last      = 1'b1;
                cmd.emit_read = status.out_free;
            end
            ST_MAC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.acc_clr = (k_reg == IDX_FIRST);
            end
            ST_DRAIN:
            begin
                cmd.mul_en = 1'b0;
            end
            ST_EMIT:
            begin
                cmd.emit_prod = status.out_free;
            end
            ST_WBACK:
            begin
                cmd.wb_en = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    `MM4_ASSERT_NEXT(a_mul_start, in_fire && (req_type == REQ_MUL), (state_reg == ST_MAC) && (i_reg == IDX_FIRST) && (j_reg == IDX_FIRST) && (k_reg == IDX_FIRST))
    `MM4_ASSERT_NEXT(a_mac_drain, (state_reg == ST_MAC) && (k_reg == IDX_LAST), state_reg == ST_DRAIN)
    `MM4_ASSERT_NEXT(a_run_done, (state_reg == ST_WBACK) && (k_reg == IDX_LAST) && (i_reg == IDX_LAST), state_reg == ST_IDLE)
    `MM4_ASSERT_SAME(a_one_left_writer, cmd.wb_en, !cmd.wr_left_in && !in_ready)

endmodule

`default_nettype wire

// ===== rtl/matrix4x4_multiply.sv =====
// 4x4 fixed-point matrix multiplier
//
// input channel (in_valid/in_ready, req_type, row, col, value): one
// transaction writes an entry of the left or right matrix, reads a left
// entry, or starts a multiply left * right whose product replaces left
// output channel (out_valid/out_ready, out_row, out_col, entry, saturated,
// last): a read gives one transaction, a multiply gives 16 in row-major
// order with last set on row 3 column 3
// in_ready is high only while the controller is idle; a write is stored
// as it is accepted, and a read passes through the read state, which
// loads the left entry into the output register once that register frees
// a multiply runs one shared 32x32 multiplier with a 66-bit accumulator:
// each entry runs the multiply-accumulate state over four products, then
// the drain and emit states, and each row ends in the write-back state,
// which copies the product row into left; in_ready stays low from the
// acceptance of a multiply until its last write-back
// a stalled receiver holds the output register and the controller waits
// in its emit or read state until the register frees
// reset clears both matrices and the output valid flag at once
`default_nettype none

module matrix4x4_multiply #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire  [1:0]                          req_type,
    input  wire  [mm4_pkg::IDX_W-1:0]           row,
    input  wire  [mm4_pkg::IDX_W-1:0]           col,
    input  wire  signed [mm4_pkg::ENTRY_W-1:0]  value,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [mm4_pkg::IDX_W-1:0]           out_row,
    output logic [mm4_pkg::IDX_W-1:0]           out_col,
    output logic signed [mm4_pkg::ENTRY_W-1:0]  entry,
    output logic                                saturated,
    output logic                                last
);
    import mm4_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: request decode, entry/row counters, write-back pacing
    mm4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .row      (row),
        .col      (col),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath: entry stores, multiplier, accumulator, clip, output register
    mm4_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_row   (out_row),
        .out_col   (out_col),
        .entry     (entry),
        .saturated (saturated),
        .last      (last)
    );

endmodule

`default_nettype wire
